### rtl/tte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_pkg: shared definitions for the tap tempo estimator
// Field widths, arithmetic constants, controller states and the structs
// passed between the controller, the serial divider and the tempo window.
// ----------------------------------------------------------------------------
package tte_pkg;

  localparam int TIME_W    = 32;
  localparam int TEMPO_W   = 18;   // Q10.8 BPM
  localparam int BPM_W     = 10;
  localparam int HELD_W    = 5;
  localparam int SUM_W     = 22;
  localparam int MIN_W     = 10;
  localparam int FRAC_W    = 8;

  localparam int TAP_WINDOW_DEF = 4;

  localparam logic [MIN_W-1:0]   FLOOR_RST     = MIN_W'(40);
  localparam logic [TEMPO_W-1:0] TEMPO_MAX     = '1;

  // 60e6 us per minute in Q8 is 15,360,000,000, a 34-bit dividend. An
  // interval at or below this limit gives a quotient of at least 2^18.
  localparam logic [TIME_W-1:0]  SAT_LIMIT     = TIME_W'(58593);

  // Serial divider: 18 quotient bits, one per step.
  localparam int DIV_STEPS = TEMPO_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
  localparam int REM_INIT_W = 16;
  // Upper and lower parts of the 34-bit dividend, split at bit 18.
  localparam logic [REM_INIT_W-1:0] DIV1_REM_INIT = REM_INIT_W'(58593);
  localparam logic [TEMPO_W-1:0]    DIV1_LO       = TEMPO_W'(196608);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV1,
    ST_CMP,
    ST_ADD,
    ST_AVG,
    ST_DIV2,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    WIN_NOP,
    WIN_CLEAR,
    WIN_SUB,
    WIN_ADD
  } win_op_t;

  typedef struct packed {
    logic                    start;
    logic [REM_INIT_W-1:0]   rem_init;
    logic [TEMPO_W-1:0]      dividend_lo;
    logic [TIME_W-1:0]       divisor;
  } div_cmd_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [TEMPO_W-1:0]      quotient;
  } div_stat_t;

  typedef struct packed {
    logic                    full;
    logic [HELD_W-1:0]       held;
    logic [SUM_W-1:0]        sum;
  } win_stat_t;

endpackage

### rtl/tte_tap_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_tap_if: tap input channel
// Valid/ready channel that carries one tap timestamp per item.
// ----------------------------------------------------------------------------
interface tte_tap_if;
  logic                        valid;
  logic                        ready;
  logic [tte_pkg::TIME_W-1:0]  tap_time;

  modport source (output valid, output tap_time, input ready);
  modport sink   (input valid, input tap_time, output ready);
endinterface

### rtl/tte_tempo_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_tempo_if: tempo result channel
// Valid/ready channel that carries the averaged tempo and window fill.
// ----------------------------------------------------------------------------
interface tte_tempo_if;
  logic                        valid;
  logic                        ready;
  logic [tte_pkg::BPM_W-1:0]   tempo_bpm;
  logic [tte_pkg::HELD_W-1:0]  taps_held;

  modport source (output valid, output tempo_bpm, output taps_held, input ready);
  modport sink   (input valid, input tempo_bpm, input taps_held, output ready);
endinterface

### rtl/tap_tempo_estimator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_tempo_estimator: tap tempo with moving average
// Turns tap timestamps into a Q10.8 tempo with a bit-serial divider and
// reports the floor of the mean over the last TAP_WINDOW tempos when full.
// ----------------------------------------------------------------------------
//
//   channel     direction  handshake       payload
//   in_tap      sink       valid / ready   tap_time  [31:0] microseconds
//   out_tempo   source     valid / ready   tempo_bpm [9:0], taps_held [4:0]
//   cfg         write      cfg_we          cfg_wdata [9:0] = tempo floor in BPM
//
// One item is in flight at a time. The first tap after reset only records its
// time and goes from ST_CHECK to ST_OUT. Later taps pass ST_CHECK, a first
// pass through the shared serial divider in ST_DIV1 (18 quotient bits, one
// per cycle), the window update in ST_CMP, ST_ADD and ST_AVG, a second pass
// in ST_DIV2 and the output load in ST_OUT; a saturated tempo skips the first
// pass, a window that is not yet full skips the second, and a tempo below the
// floor clears the window and goes on to ST_OUT. The input is ready again in
// the cycle after the load. Reset is synchronous and needs no clearing pass.
// A stalled result sits in the output register; the next item is accepted
// meanwhile and waits in its final state until that register frees.
// ----------------------------------------------------------------------------
module tap_tempo_estimator #(
  parameter int TAP_WINDOW = tte_pkg::TAP_WINDOW_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  tte_tap_if.sink                    in_tap,
  tte_tempo_if.source                out_tempo,
  input  logic                       cfg_we,
  input  logic [tte_pkg::MIN_W-1:0]  cfg_wdata
);

  tte_pkg::state_t              state_r, state_nxt;
  logic [tte_pkg::MIN_W-1:0]    tempo_floor_r;
  logic [tte_pkg::TIME_W-1:0]   last_time_r;
  logic [tte_pkg::TIME_W-1:0]   interval_r;
  logic                         time_seen_r;
  logic                         first_r;
  logic [tte_pkg::TEMPO_W-1:0]  tempo_r, tempo_nxt;
  logic [tte_pkg::BPM_W-1:0]    res_bpm_r, res_bpm_nxt;
  logic [tte_pkg::HELD_W-1:0]   res_held_r, res_held_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [tte_pkg::BPM_W-1:0]    out_bpm_r;
  logic [tte_pkg::HELD_W-1:0]   out_held_r;
  logic                         load_out;
  logic                         accept;

  tte_pkg::div_cmd_t            div_cmd;
  tte_pkg::div_stat_t           div_stat;
  tte_pkg::win_op_t             win_op;
  tte_pkg::win_stat_t           win_stat;

  assign in_tap.ready = (state_r == tte_pkg::ST_IDLE);
  assign accept       = in_tap.valid && in_tap.ready;

  tte_serial_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (div_cmd),
    .stat (div_stat)
  );

  tte_window #(
    .TAP_WINDOW(TAP_WINDOW)
  ) u_window (
    .clk  (clk),
    .rst_n(rst_n),
    .op   (win_op),
    .tempo(tempo_r),
    .stat (win_stat)
  );

  // Controller: next state, divider and window commands, result staging.
  always_comb begin
    state_nxt     = state_r;
    tempo_nxt     = tempo_r;
    res_bpm_nxt   = res_bpm_r;
    res_held_nxt  = res_held_r;
    win_op        = tte_pkg::WIN_NOP;
    load_out      = 1'b0;
    div_cmd.start       = 1'b0;
    div_cmd.rem_init    = tte_pkg::DIV1_REM_INIT;
    div_cmd.dividend_lo = tte_pkg::DIV1_LO;
    div_cmd.divisor     = interval_r;
    case (state_r)
      tte_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = tte_pkg::ST_CHECK;
        end
      end
      tte_pkg::ST_CHECK: begin
        if (first_r) begin
          // The first tap only records its time.
          res_bpm_nxt  = '0;
          res_held_nxt = win_stat.held;
          state_nxt    = tte_pkg::ST_OUT;
        end else if (interval_r <= tte_pkg::SAT_LIMIT) begin
          // Short or zero interval: the tempo clips at full scale.
          tempo_nxt = tte_pkg::TEMPO_MAX;
          state_nxt = tte_pkg::ST_CMP;
        end else begin
          div_cmd.start = 1'b1;
          state_nxt     = tte_pkg::ST_DIV1;
        end
      end
      tte_pkg::ST_DIV1: begin
        if (div_stat.done) begin
          tempo_nxt = div_stat.quotient;
          state_nxt = tte_pkg::ST_CMP;
        end
      end
      tte_pkg::ST_CMP: begin
        if (tempo_r < {tempo_floor_r, tte_pkg::FRAC_W'(0)}) begin
          // Too slow: drop the whole window.
          win_op       = tte_pkg::WIN_CLEAR;
          res_bpm_nxt  = '0;
          res_held_nxt = '0;
          state_nxt    = tte_pkg::ST_OUT;
        end else begin
          win_op    = tte_pkg::WIN_SUB;
          state_nxt = tte_pkg::ST_ADD;
        end
      end
      tte_pkg::ST_ADD: begin
        win_op    = tte_pkg::WIN_ADD;
        state_nxt = tte_pkg::ST_AVG;
      end
      tte_pkg::ST_AVG: begin
        res_held_nxt = win_stat.held;
        if (win_stat.full) begin
          // Mean in whole BPM: drop the fraction, then divide by the window.
          div_cmd.start       = 1'b1;
          div_cmd.rem_init    = '0;
          div_cmd.dividend_lo = tte_pkg::TEMPO_W'(win_stat.sum[tte_pkg::SUM_W-1:tte_pkg::FRAC_W]);
          div_cmd.divisor     = tte_pkg::TIME_W'(TAP_WINDOW);
          state_nxt           = tte_pkg::ST_DIV2;
        end else begin
          res_bpm_nxt = '0;
          state_nxt   = tte_pkg::ST_OUT;
        end
      end
      tte_pkg::ST_DIV2: begin
        if (div_stat.done) begin
          res_bpm_nxt = div_stat.quotient[tte_pkg::BPM_W-1:0];
          state_nxt   = tte_pkg::ST_OUT;
        end
      end
      tte_pkg::ST_OUT: begin
        if (!out_valid_r || out_tempo.ready) begin
          load_out  = 1'b1;
          state_nxt = tte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = tte_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tempo.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tte_pkg::ST_IDLE;
      tempo_floor_r <= tte_pkg::FLOOR_RST;
      last_time_r   <= '0;
      time_seen_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        tempo_floor_r <= cfg_wdata;
      end
      if (accept) begin
        last_time_r <= in_tap.tap_time;
        time_seen_r <= 1'b1;
      end
    end
  end

  // Payload registers; the interval wraps modulo 2^32 by construction.
  always_ff @(posedge clk) begin
    tempo_r    <= tempo_nxt;
    res_bpm_r  <= res_bpm_nxt;
    res_held_r <= res_held_nxt;
    if (accept) begin
      interval_r <= in_tap.tap_time - last_time_r;
      first_r    <= !time_seen_r;
    end
    if (load_out) begin
      out_bpm_r  <= res_bpm_r;
      out_held_r <= res_held_r;
    end
  end

  assign out_tempo.valid     = out_valid_r;
  assign out_tempo.tempo_bpm = out_bpm_r;
  assign out_tempo.taps_held = out_held_r;

  // A new result never overwrites one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> !out_valid_r || out_tempo.ready)
    else $error("result register overwritten while stalled");

  // The divider is running or finishing whenever the controller waits on it.
  a_div_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tte_pkg::ST_DIV1 || state_r == tte_pkg::ST_DIV2)
      |-> div_stat.busy || div_stat.done)
    else $error("controller waits on an idle divider");

  // An accepted tap always starts its evaluation in the next cycle.
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == tte_pkg::ST_CHECK)
    else $error("accepted tap not evaluated");

endmodule

### rtl/tte_serial_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_serial_div: radix-2 restoring divider
// Shifts the low dividend bits in one per cycle and forms one quotient bit
// per cycle; the caller guarantees the quotient fits in 18 bits.
// ----------------------------------------------------------------------------
module tte_serial_div (
  input  logic                clk,
  input  logic                rst_n,
  input  tte_pkg::div_cmd_t   cmd,
  output tte_pkg::div_stat_t  stat
);

  logic [tte_pkg::TIME_W-1:0]    rem_r, rem_nxt;
  logic [tte_pkg::TIME_W-1:0]    divisor_r;
  logic [tte_pkg::TEMPO_W-1:0]   q_sr_r, q_sr_nxt;
  logic [tte_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                          busy_r, busy_nxt;
  logic                          done_r, done_nxt;
  logic [tte_pkg::TIME_W:0]      trial;
  logic [tte_pkg::TIME_W:0]      diff;
  logic                          ge;

  // Remainder shifted left with the next dividend bit brought in.
  assign trial = {rem_r, q_sr_r[tte_pkg::TEMPO_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign ge    = trial >= {1'b0, divisor_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_sr_nxt = q_sr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (cmd.start && !busy_r) begin
      rem_nxt  = tte_pkg::TIME_W'(cmd.rem_init);
      q_sr_nxt = cmd.dividend_lo;
      cnt_nxt  = tte_pkg::DIV_CNT_W'(tte_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[tte_pkg::TIME_W-1:0] : trial[tte_pkg::TIME_W-1:0];
      q_sr_nxt = {q_sr_r[tte_pkg::TEMPO_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == tte_pkg::DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    q_sr_r <= q_sr_nxt;
    if (cmd.start && !busy_r) begin
      divisor_r <= cmd.divisor;
    end
  end

  assign stat.busy     = busy_r;
  assign stat.done     = done_r;
  assign stat.quotient = q_sr_r;

  // The remainder must stay below the divisor or the quotient overflows.
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rem_r < divisor_r)
    else $error("divider remainder reached divisor");

  // Completion follows the last step and never overlaps a running division.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r)
    else $error("divider done without a finished run");

endmodule

### rtl/tte_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_window: ring of recent tempos with running sum
// Holds the last TAP_WINDOW tempos, their sum and the fill count. An update
// takes two operations: retire the oldest entry, then add the new one.
// ----------------------------------------------------------------------------
module tte_window #(
  parameter int TAP_WINDOW = tte_pkg::TAP_WINDOW_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tte_pkg::win_op_t             op,
  input  logic [tte_pkg::TEMPO_W-1:0]  tempo,
  output tte_pkg::win_stat_t           stat
);

  localparam int PTR_W = $clog2(TAP_WINDOW);

  logic [tte_pkg::TEMPO_W-1:0] ring_r [TAP_WINDOW];
  logic [PTR_W-1:0]            ptr_r, ptr_nxt;
  logic [tte_pkg::HELD_W-1:0]  held_r, held_nxt;
  logic [tte_pkg::SUM_W-1:0]   sum_r, sum_nxt;
  logic                        full;

  assign full = held_r >= tte_pkg::HELD_W'(TAP_WINDOW);

  always_comb begin
    ptr_nxt  = ptr_r;
    held_nxt = held_r;
    sum_nxt  = sum_r;
    case (op)
      tte_pkg::WIN_CLEAR: begin
        ptr_nxt  = '0;
        held_nxt = '0;
        sum_nxt  = '0;
      end
      tte_pkg::WIN_SUB: begin
        if (full) begin
          sum_nxt = sum_r - tte_pkg::SUM_W'(ring_r[ptr_r]);
        end else begin
          held_nxt = held_r + 1'b1;
        end
      end
      tte_pkg::WIN_ADD: begin
        sum_nxt = sum_r + tte_pkg::SUM_W'(tempo);
        ptr_nxt = (ptr_r == PTR_W'(TAP_WINDOW - 1)) ? '0 : ptr_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r  <= '0;
      held_r <= '0;
      sum_r  <= '0;
    end else begin
      ptr_r  <= ptr_nxt;
      held_r <= held_nxt;
      sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (op == tte_pkg::WIN_ADD) begin
      ring_r[ptr_r] <= tempo;
    end
  end

  assign stat.full = full;
  assign stat.held = held_r;
  assign stat.sum  = sum_r;

  // The fill count saturates at the window size.
  a_held_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= tte_pkg::HELD_W'(TAP_WINDOW))
    else $error("window fill count exceeds window size");

endmodule
